FILE: rtl/core/sps_pkg.sv
// Shared types, constants and helper functions for the SPS header parser.
`default_nettype none
package sps_pkg;

	localparam int unsigned MaxSetIdsDefault   = 32;
	localparam int unsigned MaxPocCycleDefault = 256;
	localparam int unsigned ByteQueueDepth     = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} sps_in_t;

	typedef struct packed {
		logic [7:0]  profile;
		logic [7:0]  level;
		logic [4:0]  set_id;
		logic [3:0]  log2_frame_num;
		logic [7:0]  poc_kind;
		logic [3:0]  log2_poc_lsb;
		logic        frames_only;
		logic [16:0] width_px;
		logic [17:0] height_px;
		logic [15:0] aspect_num;
		logic [15:0] aspect_den;
		logic [1:0]  status;
	} sps_out_t;

	// Byte handed from the front end to the bit parser.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       drop;
		logic       last_byte;
	} sps_work_t;

	typedef enum logic [5:0] {
		ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_ID, ST_CHROMA, ST_SEP, ST_DEPTH_L,
		ST_DEPTH_C, ST_BYPASS, ST_MATRIX, ST_LIST_FLAG, ST_DELTA, ST_FRAME_NUM,
		ST_POC_TYPE, ST_POC_LSB, ST_ALWAYS_ZERO, ST_OFF_NONREF, ST_OFF_FIELD,
		ST_CYCLE, ST_OFF_REF, ST_NUM_REF, ST_GAPS, ST_WIDTH, ST_HEIGHT,
		ST_FRAMES_ONLY, ST_MBAFF, ST_DIRECT, ST_CROP, ST_CROP_VAL, ST_VUI,
		ST_AR_FLAG, ST_AR_IDC, ST_SAR_W, ST_SAR_H, ST_DONE, ST_BAD
	} sps_step_t;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_BADID = 2'd1;
	localparam logic [1:0] STATUS_SHORT = 2'd2;

	function automatic logic is_golomb(input sps_step_t s);
		case (s)
			ST_ID, ST_CHROMA, ST_DEPTH_L, ST_DEPTH_C, ST_DELTA, ST_FRAME_NUM,
			ST_POC_TYPE, ST_POC_LSB, ST_OFF_NONREF, ST_OFF_FIELD, ST_CYCLE,
			ST_OFF_REF, ST_NUM_REF, ST_WIDTH, ST_HEIGHT, ST_CROP_VAL: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [5:0] fixed_width(input sps_step_t s);
		case (s)
			ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_AR_IDC: return 6'd8;
			ST_SAR_W, ST_SAR_H:                        return 6'd16;
			ST_DONE, ST_BAD:                           return 6'd0;
			default: return is_golomb(s) ? 6'd0 : 6'd1;
		endcase
	endfunction

	// Predefined sample aspect ratios, numerator in the upper byte.
	function automatic logic [15:0] sar_entry(input logic [4:0] idx);
		case (idx)
			5'd1:  return {8'd1, 8'd1};
			5'd2:  return {8'd12, 8'd11};
			5'd3:  return {8'd10, 8'd11};
			5'd4:  return {8'd16, 8'd11};
			5'd5:  return {8'd40, 8'd33};
			5'd6:  return {8'd24, 8'd11};
			5'd7:  return {8'd20, 8'd11};
			5'd8:  return {8'd32, 8'd11};
			5'd9:  return {8'd80, 8'd33};
			5'd10: return {8'd18, 8'd11};
			5'd11: return {8'd15, 8'd11};
			5'd12: return {8'd64, 8'd33};
			5'd13: return {8'd160, 8'd99};
			5'd14: return {8'd4, 8'd3};
			5'd15: return {8'd3, 8'd2};
			5'd16: return {8'd2, 8'd1};
			default: return {8'd1, 8'd1};
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sps_front.sv
// Front end: accepts bytes, flags emulation-prevention bytes, queues them.
`default_nettype none
module sps_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire sps_pkg::sps_in_t in_item,
	output logic                  work_valid,
	input  wire logic             work_take,
	output sps_pkg::sps_work_t    work_item
);
	import sps_pkg::*;

	localparam int unsigned PtrW = $clog2(ByteQueueDepth);

	sps_work_t       mem_q [ByteQueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0]   cnt_q;
	logic [1:0]      zero_run_q;
	logic            acc, drop;

	assign full       = (cnt_q == (PtrW+1)'(ByteQueueDepth));
	assign acc        = push && !full;
	assign work_valid = (cnt_q != '0);
	assign work_item  = mem_q[rd_q];
	assign drop       = (zero_run_q == 2'd2) && (in_item.data_byte == 8'h03);

	always_ff @(posedge clk) begin
		if (acc) begin
			mem_q[wr_q] <= '{data_byte: in_item.data_byte, drop: drop,
				last_byte: in_item.last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q       <= '0;
			rd_q       <= '0;
			cnt_q      <= '0;
			zero_run_q <= '0;
		end else begin
			if (acc) begin
				wr_q <= (wr_q == PtrW'(ByteQueueDepth-1)) ? '0 : wr_q + 1'b1;
				// The run restarts after each set ends as well.
				if (in_item.last_byte || drop || in_item.data_byte != 8'h00)
					zero_run_q <= 2'd0;
				else if (zero_run_q != 2'd2)
					zero_run_q <= zero_run_q + 2'd1;
			end
			if (work_take)
				rd_q <= (rd_q == PtrW'(ByteQueueDepth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(acc) - (PtrW+1)'(work_take);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/sps_back.sv
// Back end: bit-serial syntax parser with a one-entry result register.
`default_nettype none
module sps_back #(
	parameter int unsigned MAX_SET_IDS   = sps_pkg::MaxSetIdsDefault,
	parameter int unsigned MAX_POC_CYCLE = sps_pkg::MaxPocCycleDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               work_valid,
	output logic                    work_take,
	input  wire sps_pkg::sps_work_t work_item,
	output logic                    empty,
	input  wire logic               pop,
	output sps_pkg::sps_out_t       res
);
	import sps_pkg::*;

	sps_step_t   step_q;
	logic [5:0]  shift_q, zeros_q;
	logic [31:0] acc_q;
	logic [8:0]  loop_q;
	logic [3:0]  list_q;
	logic [7:0]  last_sc_q;
	logic [1:0]  chroma_q;
	logic        busy_q, lastb_q;
	logic [2:0]  bit_q;
	logic [7:0]  byte_q;
	logic        byte_skip_q;
	sps_out_t    f_q;
	logic        out_full_q;
	sps_out_t    out_q;

	// Working copies of the parse state.
	sps_step_t   st;
	logic [5:0]  sh, gz;
	logic [31:0] fa;
	logic [8:0]  lc;
	logic [3:0]  li;
	logic [7:0]  ls;
	logic [1:0]  ck;
	sps_out_t    f;
	logic        b, fin;
	logic [31:0] v;
	logic [32:0] vsum;
	logic [7:0]  ns, dd;
	logic [15:0] sar;
	logic [12:0] dim;
	logic        step_bit, finish_set;

	// Summary as it stands after the closing byte.
	sps_out_t    sum_f;
	sps_step_t   sum_st;

	assign empty     = !out_full_q;
	assign res       = out_q;
	assign work_take = work_valid && !busy_q && (work_item.drop || !work_item.last_byte
		|| !out_full_q || pop);
	assign step_bit  = busy_q && (!(bit_q == 3'd0 && lastb_q) || !out_full_q || pop);
	assign finish_set = busy_q && (bit_q == 3'd0) && lastb_q && (!out_full_q || pop);

	function automatic logic [12:0] dim_of(input logic [31:0] x);
		return (x > 32'd4095) ? 13'd4096 : 13'(x[11:0]) + 13'd1;
	endfunction

	always_comb begin
		st = step_q; sh = shift_q; gz = zeros_q; fa = acc_q; lc = loop_q;
		li = list_q; ls = last_sc_q; ck = chroma_q; f = f_q;
		b = byte_q[bit_q]; fin = 1'b0; v = '0; vsum = '0;
		ns = '0; dd = '0; sar = '0; dim = '0;
		if (st != ST_DONE && st != ST_BAD) begin
			if (is_golomb(st) && sh == 6'd0) begin
				if (b) begin
					if (gz == 6'd0) fin = 1'b1;
					else sh = gz;
				end else begin
					gz = gz + 6'd1;
					if (gz >= 6'd32) sh = 6'd32;
				end
			end else begin
				fa = {fa[30:0], b};
				sh = sh - 6'd1;
				if (sh == 6'd0) begin
					fin = 1'b1;
					if (is_golomb(st)) begin
						vsum = ((33'd1 << gz) - 33'd1) + {1'b0, fa};
						v = vsum[32] ? 32'hFFFF_FFFF : vsum[31:0];
					end else begin
						v = fa;
					end
				end
			end
		end
		if (fin) begin
			fa = '0; gz = '0;
			case (st)
				ST_PROFILE: begin f.profile = v[7:0]; st = ST_CONSTR; end
				ST_CONSTR:  st = ST_LEVEL;
				ST_LEVEL:   begin f.level = v[7:0]; st = ST_ID; end
				ST_ID: begin
					f.set_id = (v > 32'd31) ? 5'd31 : v[4:0];
					if (v >= 32'(MAX_SET_IDS)) st = ST_BAD;
					else if (f.profile inside {8'd100, 8'd110, 8'd122, 8'd244,
						8'd44, 8'd83, 8'd86}) st = ST_CHROMA;
					else st = ST_FRAME_NUM;
				end
				ST_CHROMA: begin
					ck = (v < 32'd4) ? v[1:0] : 2'd0;
					st = (v == 32'd3) ? ST_SEP : ST_DEPTH_L;
				end
				ST_SEP:     st = ST_DEPTH_L;
				ST_DEPTH_L: st = ST_DEPTH_C;
				ST_DEPTH_C: st = ST_BYPASS;
				ST_BYPASS:  st = ST_MATRIX;
				ST_MATRIX: begin li = '0; st = v[0] ? ST_LIST_FLAG : ST_FRAME_NUM; end
				ST_LIST_FLAG: begin
					if (v[0]) begin
						lc = '0; ls = 8'd8; st = ST_DELTA;
					end else begin
						li = li + 4'd1;
						st = (li >= ((ck == 2'd3) ? 4'd12 : 4'd8)) ? ST_FRAME_NUM
							: ST_LIST_FLAG;
					end
				end
				ST_DELTA: begin
					dd = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
					ns = ls + dd;
					if (ns != 8'd0) ls = ns;
					lc = lc + 9'd1;
					if (ns == 8'd0 || lc >= ((li < 4'd6) ? 9'd16 : 9'd64)) begin
						li = li + 4'd1;
						st = (li >= ((ck == 2'd3) ? 4'd12 : 4'd8)) ? ST_FRAME_NUM
							: ST_LIST_FLAG;
					end else st = ST_DELTA;
				end
				ST_FRAME_NUM: begin
					f.log2_frame_num = (v > 32'd12) ? 4'd12 : v[3:0];
					st = ST_POC_TYPE;
				end
				ST_POC_TYPE: begin
					f.poc_kind = (v > 32'd255) ? 8'd255 : v[7:0];
					st = (v == 32'd0) ? ST_POC_LSB : (v == 32'd1) ? ST_ALWAYS_ZERO
						: ST_NUM_REF;
				end
				ST_POC_LSB: begin
					f.log2_poc_lsb = (v > 32'd12) ? 4'd12 : v[3:0];
					st = ST_NUM_REF;
				end
				ST_ALWAYS_ZERO: st = ST_OFF_NONREF;
				ST_OFF_NONREF:  st = ST_OFF_FIELD;
				ST_OFF_FIELD:   st = ST_CYCLE;
				ST_CYCLE: begin
					lc = (v > 32'(MAX_POC_CYCLE)) ? 9'(MAX_POC_CYCLE) : v[8:0];
					st = (lc == 9'd0) ? ST_NUM_REF : ST_OFF_REF;
				end
				ST_OFF_REF: begin
					lc = lc - 9'd1;
					st = (lc == 9'd0) ? ST_NUM_REF : ST_OFF_REF;
				end
				ST_NUM_REF: st = ST_GAPS;
				ST_GAPS:    st = ST_WIDTH;
				ST_WIDTH: begin
					dim = dim_of(v);
					f.width_px = {dim, 4'd0};
					st = ST_HEIGHT;
				end
				ST_HEIGHT: begin
					dim = dim_of(v);
					f.height_px = {1'b0, dim, 4'd0};
					st = ST_FRAMES_ONLY;
				end
				ST_FRAMES_ONLY: begin
					f.frames_only = v[0];
					if (!v[0]) begin
						f.height_px = {f.height_px[16:0], 1'b0};
						st = ST_MBAFF;
					end else st = ST_DIRECT;
				end
				ST_MBAFF:  st = ST_DIRECT;
				ST_DIRECT: st = ST_CROP;
				ST_CROP: begin lc = '0; st = v[0] ? ST_CROP_VAL : ST_VUI; end
				ST_CROP_VAL: begin
					lc = lc + 9'd1;
					st = (lc >= 9'd4) ? ST_VUI : ST_CROP_VAL;
				end
				ST_VUI:     st = v[0] ? ST_AR_FLAG : ST_DONE;
				ST_AR_FLAG: st = v[0] ? ST_AR_IDC : ST_DONE;
				ST_AR_IDC: begin
					if (v == 32'd255) st = ST_SAR_W;
					else begin
						sar = (v < 32'd17) ? sar_entry(v[4:0]) : {8'd1, 8'd1};
						if (v == 32'd0) sar = {8'd1, 8'd1};
						f.aspect_num = {8'd0, sar[15:8]};
						f.aspect_den = {8'd0, sar[7:0]};
						st = ST_DONE;
					end
				end
				ST_SAR_W: begin f.aspect_num = v[15:0]; st = ST_SAR_H; end
				ST_SAR_H: begin
					if (f.aspect_num == 16'd0 || v[15:0] == 16'd0) begin
						f.aspect_num = 16'd1; f.aspect_den = 16'd1;
					end else f.aspect_den = v[15:0];
					st = ST_DONE;
				end
				default: ;
			endcase
			sh = fixed_width(st);
		end
	end

	// A dropped closing byte carries no bits, so the summary keeps the held state.
	always_comb begin
		sum_f  = byte_skip_q ? f_q : f;
		sum_st = byte_skip_q ? step_q : st;
		if (sum_f.aspect_den == 16'd0) sum_f.aspect_num = 16'd0;
		sum_f.status = (sum_st == ST_DONE) ? STATUS_OK
			: (sum_st == ST_BAD) ? STATUS_BADID : STATUS_SHORT;
	end

	always_ff @(posedge clk) begin
		if (work_take) byte_q <= work_item.data_byte;
		if (finish_set) out_q <= sum_f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_PROFILE; shift_q <= 6'd8; zeros_q <= '0; acc_q <= '0;
			loop_q <= '0; list_q <= '0; last_sc_q <= 8'd8; chroma_q <= '0;
			f_q <= '0; busy_q <= 1'b0; lastb_q <= 1'b0; bit_q <= '0;
			byte_skip_q <= 1'b0; out_full_q <= 1'b0;
		end else begin
			if (finish_set) out_full_q <= 1'b1;
			else if (pop) out_full_q <= 1'b0;
			if (work_take) begin
				// A dropped byte still can close the set.
				busy_q <= !work_item.drop || work_item.last_byte;
				bit_q <= work_item.drop ? 3'd0 : 3'd7;
				lastb_q <= work_item.last_byte;
				byte_skip_q <= work_item.drop;
			end else if (step_bit) begin
				if (bit_q == 3'd0) busy_q <= 1'b0;
				else bit_q <= bit_q - 3'd1;
				if (finish_set) begin
					step_q <= ST_PROFILE; shift_q <= 6'd8; zeros_q <= '0;
					acc_q <= '0; loop_q <= '0; list_q <= '0; last_sc_q <= 8'd8;
					chroma_q <= '0; f_q <= '0;
				end else if (!byte_skip_q) begin
					step_q <= st; shift_q <= sh; zeros_q <= gz; acc_q <= fa;
					loop_q <= lc; list_q <= li; last_sc_q <= ls; chroma_q <= ck;
					f_q <= f;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/h264_sps_header_parser.sv
// Top level of the H.264 sequence parameter set header parser.
//
//   channel   handshake        payload
//   input     push / full      in_item  (data_byte, last_byte)
//   result    empty / pop      res      (one summary per parameter set)
//
// In the back end each byte is loaded from the byte queue, then its eight bits
// are parsed, one syntax bit per cycle except for the stall described below. A
// dropped emulation-prevention byte is only loaded, and closes the set when it is
// the last byte. A two-entry byte queue lets the front end take requests while
// bits are parsed. The summary waits in a result register; the last bit of the
// next set stalls there until it is popped. Reset clears all parse state.
`default_nettype none
module h264_sps_header_parser #(
	parameter int unsigned MAX_SET_IDS   = sps_pkg::MaxSetIdsDefault,
	parameter int unsigned MAX_POC_CYCLE = sps_pkg::MaxPocCycleDefault
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire sps_pkg::sps_in_t in_item,
	output logic                  empty,
	input  wire logic             pop,
	output sps_pkg::sps_out_t     res
);
	import sps_pkg::*;

	logic      work_valid, work_take;
	sps_work_t work_item;

	sps_front u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.work_valid, .work_take, .work_item
	);

	sps_back #(.MAX_SET_IDS(MAX_SET_IDS), .MAX_POC_CYCLE(MAX_POC_CYCLE)) u_back (
		.clk, .arst_n, .work_valid, .work_take, .work_item,
		.empty, .pop, .res
	);
endmodule
`default_nettype wire

FILE: verif/h264_sps_header_parser_tb.sv
// Self-checking testbench for the H.264 sequence parameter set header parser.
`default_nettype none
module h264_sps_header_parser_tb;
	import sps_pkg::*;

	// Run length guard, in clock cycles. The slowest correct run stays far below it.
	localparam int CycleLimit = 600000;

	logic     clk;
	logic     arst_n;
	logic     push;
	logic     full;
	sps_in_t  in_item;
	logic     empty;
	logic     pop;
	sps_out_t res;

	h264_sps_header_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.in_item(in_item),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Summaries that the block still owes us, oldest first.
	sps_out_t pending_summaries[$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	// While calm is set, neither side idles.
	bit       calm = 1'b0;

	// One row of the directed stimulus. A typed summary replaces the predicted one.
	typedef struct {
		logic [7:0] data_byte;
		logic       last_byte;
		bit         typed;
		sps_out_t   summary;
	} stim_row_t;

	stim_row_t directed_rows[$];

	// Predictor state: a parser of our own that follows the syntax bit by bit.
	sps_step_t    p_step;
	int           p_zero_run;
	int           p_bits_left;
	int           p_lead_zeros;
	logic [31:0]  p_accum;
	int           p_loop;
	int           p_list;
	int           p_last_scale;
	int           p_next_scale;
	int           p_chroma;
	sps_out_t     p_fields;

	// Bits of the parameter set being generated, and its bytes after packing.
	bit           gen_bits[$];
	logic [7:0]   gen_bytes[$];

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
			field, got, want, cycle_count);
		mismatch_count++;
	endtask

	function automatic bit step_reads_ue(input sps_step_t s);
		return s inside {ST_ID, ST_CHROMA, ST_DEPTH_L, ST_DEPTH_C, ST_DELTA,
			ST_FRAME_NUM, ST_POC_TYPE, ST_POC_LSB, ST_OFF_NONREF, ST_OFF_FIELD,
			ST_CYCLE, ST_OFF_REF, ST_NUM_REF, ST_WIDTH, ST_HEIGHT, ST_CROP_VAL};
	endfunction

	function automatic int step_field_bits(input sps_step_t s);
		if (s inside {ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_AR_IDC})
			return 8;
		if (s inside {ST_SAR_W, ST_SAR_H})
			return 16;
		if (s inside {ST_DONE, ST_BAD} || step_reads_ue(s))
			return 0;
		return 1;
	endfunction

	task automatic go_to(input sps_step_t s);
		p_step = s;
		p_accum = '0;
		p_lead_zeros = 0;
		p_bits_left = step_field_bits(s);
	endtask

	task automatic clear_predictor();
		p_zero_run = 0;
		p_loop = 0;
		p_list = 0;
		p_last_scale = 8;
		p_next_scale = 8;
		p_chroma = 0;
		p_fields = '0;
		go_to(ST_PROFILE);
	endtask

	task automatic advance_list();
		p_list = (p_list + 1) & 15;
		if (p_list >= (p_chroma == 3 ? 12 : 8))
			go_to(ST_FRAME_NUM);
		else
			go_to(ST_LIST_FLAG);
	endtask

	// A zero term in the sample aspect ratio falls back to square samples.
	task automatic store_aspect(input longint unsigned w, input longint unsigned h);
		if (w == 0 || h == 0) begin
			w = 1;
			h = 1;
		end
		p_fields.aspect_num = w[15:0];
		p_fields.aspect_den = h[15:0];
	endtask

	task automatic close_field(input longint unsigned v);
		int unsigned delta;
		longint unsigned clamped;
		case (p_step)
			ST_PROFILE: begin
				p_fields.profile = v[7:0];
				go_to(ST_CONSTR);
			end
			ST_CONSTR: go_to(ST_LEVEL);
			ST_LEVEL: begin
				p_fields.level = v[7:0];
				go_to(ST_ID);
			end
			ST_ID: begin
				p_fields.set_id = v > 31 ? 5'd31 : v[4:0];
				if (v >= 32)
					go_to(ST_BAD);
				else if (p_fields.profile inside {8'd100, 8'd110, 8'd122, 8'd244,
						8'd44, 8'd83, 8'd86})
					go_to(ST_CHROMA);
				else
					go_to(ST_FRAME_NUM);
			end
			ST_CHROMA: begin
				p_chroma = v < 4 ? int'(v) : 0;
				go_to(v == 3 ? ST_SEP : ST_DEPTH_L);
			end
			ST_SEP: go_to(ST_DEPTH_L);
			ST_DEPTH_L: go_to(ST_DEPTH_C);
			ST_DEPTH_C: go_to(ST_BYPASS);
			ST_BYPASS: go_to(ST_MATRIX);
			ST_MATRIX: begin
				p_list = 0;
				go_to(v != 0 ? ST_LIST_FLAG : ST_FRAME_NUM);
			end
			ST_LIST_FLAG: begin
				if (v != 0) begin
					p_loop = 0;
					p_last_scale = 8;
					p_next_scale = 8;
					go_to(ST_DELTA);
				end else begin
					advance_list();
				end
			end
			ST_DELTA: begin
				// Signed mapping: odd codes are positive, even codes zero or negative.
				delta = v[31:0];
				delta = delta[0] ? (delta >> 1) + 1 : 0 - (delta >> 1);
				p_next_scale = (p_last_scale + delta) & 255;
				if (p_next_scale != 0)
					p_last_scale = p_next_scale;
				p_loop = (p_loop + 1) & 511;
				if (p_next_scale == 0 || p_loop >= (p_list < 6 ? 16 : 64))
					advance_list();
				else
					go_to(ST_DELTA);
			end
			ST_FRAME_NUM: begin
				p_fields.log2_frame_num = v > 12 ? 4'd12 : v[3:0];
				go_to(ST_POC_TYPE);
			end
			ST_POC_TYPE: begin
				p_fields.poc_kind = v > 255 ? 8'd255 : v[7:0];
				go_to(v == 0 ? ST_POC_LSB : v == 1 ? ST_ALWAYS_ZERO : ST_NUM_REF);
			end
			ST_POC_LSB: begin
				p_fields.log2_poc_lsb = v > 12 ? 4'd12 : v[3:0];
				go_to(ST_NUM_REF);
			end
			ST_ALWAYS_ZERO: go_to(ST_OFF_NONREF);
			ST_OFF_NONREF: go_to(ST_OFF_FIELD);
			ST_OFF_FIELD: go_to(ST_CYCLE);
			ST_CYCLE: begin
				p_loop = v > 256 ? 256 : int'(v);
				go_to(p_loop == 0 ? ST_NUM_REF : ST_OFF_REF);
			end
			ST_OFF_REF: begin
				p_loop = (p_loop - 1) & 511;
				go_to(p_loop == 0 ? ST_NUM_REF : ST_OFF_REF);
			end
			ST_NUM_REF: go_to(ST_GAPS);
			ST_GAPS: go_to(ST_WIDTH);
			ST_WIDTH: begin
				clamped = v > 4095 ? 4095 : v;
				p_fields.width_px = 17'(16 * (clamped + 1));
				go_to(ST_HEIGHT);
			end
			ST_HEIGHT: begin
				clamped = v > 4095 ? 4095 : v;
				p_fields.height_px = 18'(16 * (clamped + 1));
				go_to(ST_FRAMES_ONLY);
			end
			ST_FRAMES_ONLY: begin
				p_fields.frames_only = v[0];
				if (v == 0) begin
					// Field coding: the map height counts field rows.
					p_fields.height_px = 18'(p_fields.height_px * 2);
					go_to(ST_MBAFF);
				end else begin
					go_to(ST_DIRECT);
				end
			end
			ST_MBAFF: go_to(ST_DIRECT);
			ST_DIRECT: go_to(ST_CROP);
			ST_CROP: begin
				p_loop = 0;
				go_to(v != 0 ? ST_CROP_VAL : ST_VUI);
			end
			ST_CROP_VAL: begin
				p_loop = (p_loop + 1) & 511;
				go_to(p_loop >= 4 ? ST_VUI : ST_CROP_VAL);
			end
			ST_VUI: go_to(v != 0 ? ST_AR_FLAG : ST_DONE);
			ST_AR_FLAG: go_to(v != 0 ? ST_AR_IDC : ST_DONE);
			ST_AR_IDC: begin
				case (v)
					0:  store_aspect(0, 0);
					1:  store_aspect(1, 1);
					2:  store_aspect(12, 11);
					3:  store_aspect(10, 11);
					4:  store_aspect(16, 11);
					5:  store_aspect(40, 33);
					6:  store_aspect(24, 11);
					7:  store_aspect(20, 11);
					8:  store_aspect(32, 11);
					9:  store_aspect(80, 33);
					10: store_aspect(18, 11);
					11: store_aspect(15, 11);
					12: store_aspect(64, 33);
					13: store_aspect(160, 99);
					14: store_aspect(4, 3);
					15: store_aspect(3, 2);
					16: store_aspect(2, 1);
					255: ;
					default: store_aspect(0, 0);
				endcase
				go_to(v == 255 ? ST_SAR_W : ST_DONE);
			end
			ST_SAR_W: begin
				p_fields.aspect_num = v[15:0];
				go_to(ST_SAR_H);
			end
			ST_SAR_H: begin
				store_aspect(p_fields.aspect_num, v);
				go_to(ST_DONE);
			end
			default: ;
		endcase
	endtask

	task automatic parse_bit(input bit b);
		longint unsigned v;
		if (p_step inside {ST_DONE, ST_BAD})
			return;
		// Exp-Golomb prefix: count zeros up to the marker, or give up at 32.
		if (step_reads_ue(p_step) && p_bits_left == 0) begin
			if (b) begin
				if (p_lead_zeros == 0)
					close_field(0);
				else
					p_bits_left = p_lead_zeros;
			end else begin
				p_lead_zeros++;
				if (p_lead_zeros >= 32)
					p_bits_left = 32;
			end
			return;
		end
		p_accum = {p_accum[30:0], b};
		p_bits_left--;
		if (p_bits_left != 0)
			return;
		if (step_reads_ue(p_step)) begin
			v = ((64'd1 << p_lead_zeros) - 1) + p_accum;
			close_field(v > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : v);
		end else begin
			close_field(p_accum);
		end
	endtask

	// Feeds one accepted request; sets got with the summary on the last byte.
	task automatic predict_byte(input sps_in_t item, output sps_out_t summary,
			output bit got);
		summary = '0;
		got = 1'b0;
		if (p_zero_run == 2 && item.data_byte == 8'h03) begin
			// Emulation-prevention byte: dropped, and the zero count restarts.
			p_zero_run = 0;
		end else begin
			p_zero_run = item.data_byte == 8'h00 ? (p_zero_run < 2 ? p_zero_run + 1 : 2) : 0;
			for (int i = 7; i >= 0; i--)
				parse_bit(item.data_byte[i]);
		end
		if (!item.last_byte)
			return;
		summary = p_fields;
		if (p_fields.aspect_den == 0)
			summary.aspect_num = '0;
		summary.status = p_step == ST_DONE ? STATUS_OK :
			p_step == ST_BAD ? STATUS_BADID : STATUS_SHORT;
		clear_predictor();
		got = 1'b1;
	endtask

	// Drives one request from the falling edge and holds it until it is taken.
	task automatic send_byte(input logic [7:0] data, input logic last, input bit typed,
			input sps_out_t typed_summary);
		sps_out_t summary;
		sps_in_t  item;
		bit       got;
		item.data_byte = data;
		item.last_byte = last;
		while (!calm && $urandom_range(0, 99) < 7) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		in_item = item;
		do
			@(posedge clk);
		while (full);
		predict_byte(item, summary, got);
		if (got)
			pending_summaries.push_back(typed ? typed_summary : summary);
		@(negedge clk);
		push = 1'b0;
	endtask

	// The result side pops at random, but never idles during the calm stretch.
	always @(negedge clk) begin
		if (arst_n)
			pop <= calm || $urandom_range(0, 99) >= 7;
	end

	task automatic check_summary(input sps_out_t got, input sps_out_t want);
		if (got.profile !== want.profile)
			report_mismatch("profile", got.profile, want.profile);
		if (got.level !== want.level)
			report_mismatch("level", got.level, want.level);
		if (got.set_id !== want.set_id)
			report_mismatch("set_id", got.set_id, want.set_id);
		if (got.log2_frame_num !== want.log2_frame_num)
			report_mismatch("log2_frame_num", got.log2_frame_num, want.log2_frame_num);
		if (got.poc_kind !== want.poc_kind)
			report_mismatch("poc_kind", got.poc_kind, want.poc_kind);
		if (got.log2_poc_lsb !== want.log2_poc_lsb)
			report_mismatch("log2_poc_lsb", got.log2_poc_lsb, want.log2_poc_lsb);
		if (got.frames_only !== want.frames_only)
			report_mismatch("frames_only", got.frames_only, want.frames_only);
		if (got.width_px !== want.width_px)
			report_mismatch("width_px", got.width_px, want.width_px);
		if (got.height_px !== want.height_px)
			report_mismatch("height_px", got.height_px, want.height_px);
		if (got.aspect_num !== want.aspect_num)
			report_mismatch("aspect_num", got.aspect_num, want.aspect_num);
		if (got.aspect_den !== want.aspect_den)
			report_mismatch("aspect_den", got.aspect_den, want.aspect_den);
		if (got.status !== want.status)
			report_mismatch("status", got.status, want.status);
	endtask

	// Every popped summary is checked against the oldest one still owed.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_summaries.size() == 0)
				report_mismatch("unexpected summary", 1, 0);
			else
				check_summary(res, pending_summaries.pop_front());
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic put_bits(input longint unsigned v, input int n);
		for (int i = n - 1; i >= 0; i--)
			gen_bits.push_back(v[i]);
	endtask

	task automatic put_ue(input longint unsigned v);
		longint unsigned code;
		int len;
		code = v + 1;
		len = 0;
		while ((code >> len) != 0)
			len++;
		put_bits(0, len - 1);
		put_bits(code, len);
	endtask

	task automatic put_se(input int s);
		put_ue(s > 0 ? 2 * s - 1 : -2 * s);
	endtask

	// Thirty-two leading zeros end the prefix with no marker; 32 suffix bits follow.
	task automatic put_overlong_ue();
		put_bits(0, 32);
		put_bits($urandom, 32);
	endtask

	// Random but well-formed parameter set, occasionally truncated or with a bad id.
	task automatic build_parameter_set();
		int prof;
		int pick;
		int chroma;
		int poc;
		int cycles;
		int last_scale;
		int delta;
		int cut;
		bit high;
		int high_profiles[7] = '{100, 110, 122, 244, 44, 83, 86};
		gen_bits.delete();
		pick = $urandom_range(0, 9);
		if (pick < 4)
			prof = high_profiles[$urandom_range(0, 6)];
		else if (pick < 8)
			prof = pick == 4 ? 66 : pick == 5 ? 77 : 88;
		else
			prof = $urandom_range(0, 255);
		high = prof inside {100, 110, 122, 244, 44, 83, 86};
		put_bits(prof, 8);
		put_bits($urandom, 8);
		put_bits($urandom, 8);
		pick = $urandom_range(0, 19);
		if (pick == 0)
			put_ue($urandom_range(32, 40));
		else if (pick == 1)
			put_overlong_ue();
		else
			put_ue($urandom_range(0, 31));
		if (high) begin
			chroma = $urandom_range(0, 4);
			put_ue(chroma);
			if (chroma == 3)
				put_bits($urandom, 1);
			put_ue($urandom_range(0, 6));
			put_ue($urandom_range(0, 6));
			put_bits($urandom, 1);
			if ($urandom_range(0, 2) == 0) begin
				put_bits(1, 1);
				for (int i = 0; i < (chroma == 3 ? 12 : 8); i++) begin
					if ($urandom_range(0, 1) == 0) begin
						put_bits(0, 1);
						continue;
					end
					put_bits(1, 1);
					last_scale = 8;
					for (int j = 0; j < (i < 6 ? 16 : 64); j++) begin
						// Now and then step the scale to zero, which ends the list early.
						delta = $urandom_range(0, 9) == 0 ? -last_scale :
							int'($urandom_range(0, 16)) - 8;
						put_se(delta);
						if (((last_scale + delta) & 255) == 0)
							break;
						last_scale = (last_scale + delta) & 255;
					end
				end
			end else begin
				put_bits(0, 1);
			end
		end
		put_ue($urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 12));
		pick = $urandom_range(0, 9);
		poc = pick < 4 ? 0 : pick < 7 ? 1 : pick < 9 ? 2 : $urandom_range(3, 300);
		put_ue(poc);
		if (poc == 0) begin
			put_ue($urandom_range(0, 20));
		end else if (poc == 1) begin
			put_bits($urandom, 1);
			put_se(int'($urandom_range(0, 40)) - 20);
			put_se(int'($urandom_range(0, 40)) - 20);
			cycles = $urandom_range(0, 15) == 0 ? $urandom_range(250, 262) : $urandom_range(0, 5);
			put_ue(cycles);
			for (int i = 0; i < (cycles > 256 ? 256 : cycles); i++)
				put_se(int'($urandom_range(0, 20)) - 10);
		end
		put_ue($urandom_range(0, 16));
		put_bits($urandom, 1);
		put_ue($urandom_range(0, 19) == 0 ? $urandom_range(4090, 5000) : $urandom_range(0, 120));
		put_ue($urandom_range(0, 19) == 0 ? $urandom_range(4090, 5000) : $urandom_range(0, 70));
		pick = $urandom_range(0, 1);
		put_bits(pick, 1);
		if (pick == 0)
			put_bits($urandom, 1);
		put_bits($urandom, 1);
		pick = $urandom_range(0, 2) == 0;
		put_bits(pick, 1);
		if (pick)
			for (int i = 0; i < 4; i++)
				put_ue($urandom_range(0, 30));
		pick = $urandom_range(0, 3) != 0;
		put_bits(pick, 1);
		if (pick) begin
			pick = $urandom_range(0, 4) != 0;
			put_bits(pick, 1);
			if (pick) begin
				pick = $urandom_range(0, 5);
				if (pick < 2) begin
					put_bits(255, 8);
					put_bits($urandom_range(0, 7) == 0 ? 0 : $urandom, 16);
					put_bits($urandom_range(0, 7) == 0 ? 0 : $urandom, 16);
				end else if (pick < 5) begin
					put_bits($urandom_range(0, 16), 8);
				end else begin
					put_bits($urandom_range(17, 254), 8);
				end
			end
		end
		put_bits(1, 1);
		if ($urandom_range(0, 7) == 0) begin
			cut = $urandom_range(0, gen_bits.size() - 1);
			while (gen_bits.size() > cut)
				void'(gen_bits.pop_back());
		end
		while (gen_bits.size() % 8 != 0)
			gen_bits.push_back(1'b0);
		if ($urandom_range(0, 3) == 0)
			put_bits($urandom, 8 * $urandom_range(1, 3));
	endtask

	// Packs the bits into bytes, mostly inserting emulation-prevention bytes.
	task automatic pack_bytes();
		logic [7:0] b;
		int zeros;
		gen_bytes.delete();
		zeros = 0;
		for (int i = 0; i < gen_bits.size(); i += 8) begin
			for (int k = 0; k < 8; k++)
				b[7 - k] = gen_bits[i + k];
			if (zeros >= 2 && b <= 8'h03 && $urandom_range(0, 9) != 0) begin
				gen_bytes.push_back(8'h03);
				zeros = 0;
			end
			gen_bytes.push_back(b);
			zeros = b == 8'h00 ? zeros + 1 : 0;
		end
		if (gen_bytes.size() == 0)
			gen_bytes.push_back(8'($urandom));
	endtask

	task automatic add_row(input logic [7:0] data, input logic last);
		stim_row_t row;
		row.data_byte = data;
		row.last_byte = last;
		row.typed = 1'b0;
		row.summary = '0;
		directed_rows.push_back(row);
	endtask

	// Marks the newest row with a summary read straight off the syntax.
	task automatic type_last_row(input sps_out_t summary);
		directed_rows[directed_rows.size() - 1].typed = 1'b1;
		directed_rows[directed_rows.size() - 1].summary = summary;
	endtask

	initial begin
		sps_out_t want;
		int bytes_sent;
		int noise_len;
		push = 1'b0;
		pop = 1'b0;
		in_item = '0;
		arst_n = 1'b0;
		clear_predictor();

		// A one-byte set of all ones: only the profile is read before it ends.
		add_row(8'hFF, 1'b1);
		want = '0;
		want.profile = 8'hFF;
		want.status = STATUS_SHORT;
		type_last_row(want);
		// A one-byte set of all zeros.
		add_row(8'h00, 1'b1);
		want = '0;
		want.status = STATUS_SHORT;
		type_last_row(want);
		// Set id 32 is out of range: it saturates and parsing stops.
		add_row(8'h42, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'h1E, 1'b0);
		add_row(8'h04, 1'b0);
		add_row(8'h3F, 1'b1);
		want = '0;
		want.profile = 8'h42;
		want.level = 8'h1E;
		want.set_id = 5'd31;
		want.status = STATUS_BADID;
		type_last_row(want);
		// An emulation-prevention byte after two zeros is dropped.
		add_row(8'h00, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'h03, 1'b0);
		add_row(8'h01, 1'b1);
		// A complete baseline set: 320x240 frames, POC type 2, no VUI.
		add_row(8'd66, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'd30, 1'b0);
		add_row(8'hDA, 1'b0);
		add_row(8'h05, 1'b0);
		add_row(8'h07, 1'b0);
		add_row(8'hE4, 1'b1);
		want = '0;
		want.profile = 8'd66;
		want.level = 8'd30;
		want.poc_kind = 8'd2;
		want.frames_only = 1'b1;
		want.width_px = 17'd320;
		want.height_px = 18'd240;
		want.status = STATUS_OK;
		type_last_row(want);
		// High profile with scaling lists cut short by the last byte.
		add_row(8'd100, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'd40, 1'b0);
		add_row(8'hAD, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'h03, 1'b0);
		add_row(8'h00, 1'b1);

		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_byte(directed_rows[i].data_byte, directed_rows[i].last_byte,
				directed_rows[i].typed, directed_rows[i].summary);

		// Random part: mostly well-formed sets, some raw noise sets, and one calm stretch.
		bytes_sent = 0;
		want = '0;
		while (bytes_sent < 1600) begin
			calm = bytes_sent >= 600 && bytes_sent < 900;
			if ($urandom_range(0, 5) == 0) begin
				noise_len = $urandom_range(1, 12);
				for (int i = 0; i < noise_len; i++)
					send_byte(8'($urandom), i == noise_len - 1, 1'b0, want);
				bytes_sent += noise_len;
			end else begin
				build_parameter_set();
				pack_bytes();
				foreach (gen_bytes[i])
					send_byte(gen_bytes[i], i == gen_bytes.size() - 1, 1'b0, want);
				bytes_sent += gen_bytes.size();
			end
		end
		calm = 1'b0;

		while (pending_summaries.size() != 0)
			@(posedge clk);
		repeat (100)
			@(posedge clk);
		if (mismatch_count == 0 && pending_summaries.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
